// File: src/aiks_pkg.sv
// ----------------------------------------------------------------------------
// aiks_pkg: shared types and constants for the arm inverse kinematics servo
// Fixed-point formats, cell payload structs, CORDIC arctangent table and the
// servo offset constants used across the datapath.
// ----------------------------------------------------------------------------
package aiks_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int CORDIC_MAX        = 30;
  localparam int DIV_BITS          = 30;   // quotient bits of the cosine divider
  localparam int SQRT_BITS         = 32;   // root bits of each square root lane
  localparam int CW                = 50;   // CORDIC vector width
  localparam int ZW                = 24;   // angle width, 1/16384 degree
  localparam int NLANE             = 4;    // parallel atan2 lanes
  localparam int NW                = 26;   // servo numerator width

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_BASE_HEIGHT = 2'd0,
    REG_UPPER_ARM   = 2'd1,
    REG_FOREARM     = 2'd2
  } reg_idx_t;

  localparam logic signed [15:0] BASE_HEIGHT_RST = 16'sd0;
  localparam logic [14:0]        UPPER_ARM_RST   = 15'd1600;
  localparam logic [14:0]        FOREARM_RST     = 15'd1600;

  typedef logic signed [CW-1:0] cval_t;
  typedef logic signed [ZW-1:0] ang_t;

  localparam ang_t DEG90 = 24'sd1474560;

  // arctangent of 2^-i in 1/16384 degree, rounded to nearest
  localparam int ATAN_TAB [CORDIC_MAX] = '{
    737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7, 4, 2,
    1, 0, 0, 0, 0, 0, 0, 0, 0, 0
  };

  // servo offsets folded with the fixed angle terms, 1/16384 degree
  localparam logic signed [NW-1:0] OFS_BASE     = 26'sd1146240;
  localparam logic signed [NW-1:0] OFS_SHOULDER = 26'sd1693440;
  localparam logic signed [NW-1:0] OFS_ELBOW    = 26'sd3081600;
  localparam logic signed [NW-1:0] OFS_PITCH    = 26'sd2649600;
  localparam logic signed [NW-1:0] OFS_ROLL     = 26'sd1474560;
  localparam logic signed [NW-1:0] SERVO_CAP_N  = 26'sd5898240;  // 4096 * 1440
  localparam logic [11:0]          SERVO_MAX    = 12'd4095;
  localparam logic [17:0]          RECIP_45     = 18'd186414;    // ceil(2^23 / 45)

  typedef struct packed {
    logic [31:0]          rem;
    logic [DIV_BITS-1:0]  quo;
  } div_t;

  typedef struct packed {
    logic [63:0]          rad;
    logic [33:0]          rem;
    logic [SQRT_BITS-1:0] root;
  } sq_t;

  typedef struct packed {
    cval_t x;
    cval_t y;
    ang_t  z;
    logic  zero;
  } cord_t;

  // side data riding along the divider row
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [16:0] h;
    logic [31:0]        xy2;
    logic               reject;
    logic               cpos;
    logic               cneg;
    logic               neg;
  } dside_t;

  // side data riding along the square root row
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [16:0] h;
    logic signed [31:0] c;
    logic               reject;
  } sside_t;

  // quadrant pre-rotation ahead of the vectoring iterations
  function automatic cord_t prerot(input cval_t yv, input cval_t xv);
    cord_t r;
    r.zero = (xv == '0) && (yv == '0);
    if (xv < 0) begin
      if (yv >= 0) begin
        r.x = yv;
        r.y = -xv;
        r.z = DEG90;
      end else begin
        r.x = -yv;
        r.y = xv;
        r.z = -DEG90;
      end
    end else begin
      r.x = xv;
      r.y = yv;
      r.z = '0;
    end
    return r;
  endfunction

endpackage

// File: src/aiks_div_cell.sv
// ----------------------------------------------------------------------------
// aiks_div_cell: one restoring division step
// Resolves one quotient bit of rem * 2^k / den and hands remainder, partial
// quotient and side data to the next cell.
// ----------------------------------------------------------------------------
module aiks_div_cell #(
  parameter int PW = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  aiks_pkg::div_t    d_in,
  input  logic [PW-1:0]     side_in,
  input  logic [30:0]       den,
  output logic              out_valid,
  output aiks_pkg::div_t    d_out,
  output logic [PW-1:0]     side_out
);

  logic [31:0] sh;
  logic        ge;

  // shift in a zero and try the subtraction
  assign sh = {d_in.rem[30:0], 1'b0};
  assign ge = sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out.rem <= ge ? (sh - {1'b0, den}) : sh;
      d_out.quo <= {d_in.quo[aiks_pkg::DIV_BITS-2:0], ge};
      side_out  <= side_in;
    end
  end

endmodule

// File: src/aiks_sqrt_cell.sv
// ----------------------------------------------------------------------------
// aiks_sqrt_cell: one digit step of two integer square roots
// Takes the next two radicand bits in each lane and resolves one root bit.
// ----------------------------------------------------------------------------
module aiks_sqrt_cell #(
  parameter int PW = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  aiks_pkg::sq_t [1:0] lane_in,
  input  logic [PW-1:0]       side_in,
  output logic                out_valid,
  output aiks_pkg::sq_t [1:0] lane_out,
  output logic [PW-1:0]       side_out
);

  localparam int RB = aiks_pkg::SQRT_BITS;

  for (genvar g = 0; g < 2; g++) begin : g_lane
    logic [35:0] cur;
    logic [35:0] trial;
    logic [35:0] diff;
    logic        ge;

    // bring down two radicand bits, compare against 4*root + 1
    assign cur   = {lane_in[g].rem, lane_in[g].rad[63:62]};
    assign trial = {2'b00, lane_in[g].root, 2'b01};
    assign ge    = cur >= trial;
    assign diff  = cur - trial;

    always_ff @(posedge clk) begin
      if (en) begin
        lane_out[g].rad  <= {lane_in[g].rad[61:0], 2'b00};
        lane_out[g].rem  <= ge ? diff[33:0] : cur[33:0];
        lane_out[g].root <= {lane_in[g].root[RB-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_out <= side_in;
    end
  end

endmodule

// File: src/aiks_cordic_cell.sv
// ----------------------------------------------------------------------------
// aiks_cordic_cell: one vectoring CORDIC micro-rotation over all lanes
// Rotates each lane toward the x axis by atan(2^-STAGE), accumulating angle.
// ----------------------------------------------------------------------------
module aiks_cordic_cell #(
  parameter int STAGE = 0,
  parameter int PW    = 1
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  aiks_pkg::cord_t [aiks_pkg::NLANE-1:0] lane_in,
  input  logic [PW-1:0]                         side_in,
  output logic                                  out_valid,
  output aiks_pkg::cord_t [aiks_pkg::NLANE-1:0] lane_out,
  output logic [PW-1:0]                         side_out
);

  localparam aiks_pkg::ang_t STEP = aiks_pkg::ang_t'(aiks_pkg::ATAN_TAB[STAGE]);

  for (genvar g = 0; g < aiks_pkg::NLANE; g++) begin : g_lane
    aiks_pkg::cval_t dx;
    aiks_pkg::cval_t dy;
    logic            up;

    assign dx = lane_in[g].y >>> STAGE;
    assign dy = lane_in[g].x >>> STAGE;
    assign up = !lane_in[g].y[aiks_pkg::CW-1];

    // rotate clockwise while y is non-negative
    always_ff @(posedge clk) begin
      if (en) begin
        lane_out[g].x    <= up ? (lane_in[g].x + dx) : (lane_in[g].x - dx);
        lane_out[g].y    <= up ? (lane_in[g].y - dy) : (lane_in[g].y + dy);
        lane_out[g].z    <= up ? (lane_in[g].z + STEP) : (lane_in[g].z - STEP);
        lane_out[g].zero <= lane_in[g].zero;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_out <= side_in;
    end
  end

endmodule

// File: src/arm_inverse_kinematics_servo.sv
// ----------------------------------------------------------------------------
// arm_inverse_kinematics_servo: pipelined inverse kinematics for a base plus
// two-link arm, producing five 12-bit servo positions per target point.
// ----------------------------------------------------------------------------
// The block accepts one target point per clock and returns one result per
// point, in order, after passing through four setup stages, a 30-cell
// divider row for the elbow cosine, two stages, a 32-cell square root row
// (sine and radial distance side by side), product and pre-rotation stages,
// a CORDIC row of CORDIC_STAGES cells running four atan2 lanes, and three
// servo conversion stages. The whole pipeline advances together, so it
// halts only while a finished result sits in the output register untaken.
// ----------------------------------------------------------------------------
module arm_inverse_kinematics_servo #(
  parameter int CORDIC_STAGES = aiks_pkg::CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // target_x, target_y, target_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // reachable, joint_base, joint_shoulder,
                                      // joint_elbow, joint_wrist_pitch,
                                      // joint_wrist_roll, zero fill
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int DB  = aiks_pkg::DIV_BITS;
  localparam int SB  = aiks_pkg::SQRT_BITS;
  localparam int NL  = aiks_pkg::NLANE;
  localparam int NW  = aiks_pkg::NW;
  localparam int ZW  = aiks_pkg::ZW;
  localparam int DSW = $bits(aiks_pkg::dside_t);
  localparam int SSW = $bits(aiks_pkg::sside_t);

  logic en;

  // --------------------------------------------------------------------------
  // configuration registers and derived link terms
  // --------------------------------------------------------------------------
  logic signed [15:0] base_height;
  logic [14:0]        upper_arm_length;
  logic [14:0]        forearm_length;
  logic [29:0]        l1l2;
  logic [29:0]        l1sq;
  logic [29:0]        l2sq;
  logic [30:0]        den_q;
  logic [30:0]        lsum_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_height      <= aiks_pkg::BASE_HEIGHT_RST;
      upper_arm_length <= aiks_pkg::UPPER_ARM_RST;
      forearm_length   <= aiks_pkg::FOREARM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        aiks_pkg::REG_BASE_HEIGHT: base_height      <= cfg_data;
        aiks_pkg::REG_UPPER_ARM:   upper_arm_length <= cfg_data[14:0];
        aiks_pkg::REG_FOREARM:     forearm_length   <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  assign l1l2 = upper_arm_length * forearm_length;
  assign l1sq = upper_arm_length * upper_arm_length;
  assign l2sq = forearm_length * forearm_length;

  // law-of-cosines denominator and link square sum
  always_ff @(posedge clk) begin
    den_q  <= {l1l2, 1'b0};
    lsum_q <= {1'b0, l1sq} + {1'b0, l2sq};
  end

  // --------------------------------------------------------------------------
  // S0: capture the target and the height above the shoulder
  // --------------------------------------------------------------------------
  logic               v0;
  logic signed [15:0] x0, y0;
  logic signed [16:0] h0;

  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0 <= s_axis_tdata[15:0];
      y0 <= s_axis_tdata[31:16];
      h0 <= {s_axis_tdata[47], s_axis_tdata[47:32]} - {base_height[15], base_height};
    end
  end

  // --------------------------------------------------------------------------
  // S1: squares
  // --------------------------------------------------------------------------
  logic               v1;
  logic signed [15:0] x1, y1;
  logic signed [16:0] h1;
  logic signed [31:0] xsq, ysq;
  logic signed [33:0] hsq;
  logic [31:0]        xy2_1;
  logic [32:0]        hsq_1;

  assign xsq = x0 * x0;
  assign ysq = y0 * y0;
  assign hsq = h0 * h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1    <= x0;
      y1    <= y0;
      h1    <= h0;
      xy2_1 <= xsq[31:0] + ysq[31:0];
      hsq_1 <= hsq[32:0];
    end
  end

  // --------------------------------------------------------------------------
  // S2: cosine numerator
  // --------------------------------------------------------------------------
  logic               v2;
  logic signed [15:0] x2, y2;
  logic signed [16:0] h2;
  logic [31:0]        xy2_2;
  logic signed [35:0] num2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2    <= x1;
      y2    <= y1;
      h2    <= h1;
      xy2_2 <= xy2_1;
      num2  <= $signed({4'b0, xy2_1}) + $signed({3'b0, hsq_1}) - $signed({5'b0, lsum_q});
    end
  end

  // --------------------------------------------------------------------------
  // S3: reach test, clamp detection and divider operand
  // --------------------------------------------------------------------------
  logic               v3;
  logic signed [46:0] t1000;
  logic signed [46:0] d1001;
  logic signed [35:0] den_w;
  logic signed [35:0] mag;
  logic               rej_c, cpos_c, cneg_c;
  aiks_pkg::div_t     d3;
  aiks_pkg::dside_t   side3;

  assign t1000  = num2 * 47'sd1000;
  assign d1001  = $signed({16'b0, den_q}) * 47'sd1001;
  assign den_w  = $signed({5'b0, den_q});
  assign mag    = num2[35] ? -num2 : num2;
  assign rej_c  = (den_q == '0) || (t1000 > d1001) || (t1000 < -d1001);
  assign cpos_c = num2 >= den_w;
  assign cneg_c = num2 <= -den_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d3.rem       <= (rej_c || cpos_c || cneg_c) ? '0 : {1'b0, mag[30:0]};
      d3.quo       <= '0;
      side3.x      <= x2;
      side3.y      <= y2;
      side3.h      <= h2;
      side3.xy2    <= xy2_2;
      side3.reject <= rej_c;
      side3.cpos   <= cpos_c;
      side3.cneg   <= cneg_c;
      side3.neg    <= num2[35];
    end
  end

  // --------------------------------------------------------------------------
  // divider row: |num| * 2^30 / den
  // --------------------------------------------------------------------------
  aiks_pkg::div_t   dv   [DB+1];
  logic [DSW-1:0]   ds   [DB+1];
  logic             dvld [DB+1];

  assign dv[0]   = d3;
  assign ds[0]   = side3;
  assign dvld[0] = v3;

  for (genvar k = 0; k < DB; k++) begin : g_div
    aiks_div_cell #(.PW(DSW)) u_div (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (dvld[k]),
      .d_in      (dv[k]),
      .side_in   (ds[k]),
      .den       (den_q),
      .out_valid (dvld[k+1]),
      .d_out     (dv[k+1]),
      .side_out  (ds[k+1])
    );
  end

  // --------------------------------------------------------------------------
  // S4: signed, clamped cosine
  // --------------------------------------------------------------------------
  aiks_pkg::dside_t   dsf;
  logic signed [31:0] qs;
  logic signed [31:0] c_c;
  logic               v4;
  logic signed [31:0] c4;
  aiks_pkg::dside_t   side4;

  assign dsf = aiks_pkg::dside_t'(ds[DB]);
  assign qs  = $signed({2'b00, dv[DB].quo});

  always_comb begin
    if (dsf.cpos) begin
      c_c = 32'sh4000_0000;
    end else if (dsf.cneg) begin
      c_c = -32'sh4000_0000;
    end else if (dsf.neg) begin
      c_c = -qs;
    end else begin
      c_c = qs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= dvld[DB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c4    <= c_c;
      side4 <= dsf;
    end
  end

  // --------------------------------------------------------------------------
  // S5: square root radicands
  // --------------------------------------------------------------------------
  logic signed [63:0]  csq;
  logic                v5;
  aiks_pkg::sq_t [1:0] sq5;
  aiks_pkg::sside_t    side5;

  assign csq = c4 * c4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq5[0].rad    <= 64'h1000_0000_0000_0000 - csq;
      sq5[0].rem    <= '0;
      sq5[0].root   <= '0;
      sq5[1].rad    <= {side4.xy2, 32'b0};
      sq5[1].rem    <= '0;
      sq5[1].root   <= '0;
      side5.x       <= side4.x;
      side5.y       <= side4.y;
      side5.h       <= side4.h;
      side5.c       <= c4;
      side5.reject  <= side4.reject;
    end
  end

  // --------------------------------------------------------------------------
  // square root row: sine in lane 0, radial distance in lane 1
  // --------------------------------------------------------------------------
  aiks_pkg::sq_t [1:0] sq   [SB+1];
  logic [SSW-1:0]      ss   [SB+1];
  logic                svld [SB+1];

  assign sq[0]   = sq5;
  assign ss[0]   = side5;
  assign svld[0] = v5;

  for (genvar k = 0; k < SB; k++) begin : g_sqrt
    aiks_sqrt_cell #(.PW(SSW)) u_sqrt (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (svld[k]),
      .lane_in   (sq[k]),
      .side_in   (ss[k]),
      .out_valid (svld[k+1]),
      .lane_out  (sq[k+1]),
      .side_out  (ss[k+1])
    );
  end

  // --------------------------------------------------------------------------
  // S6: atan2 operands for the four lanes
  // --------------------------------------------------------------------------
  aiks_pkg::sside_t   ssf;
  logic [SB-1:0]      s_val, r_val;
  logic [46:0]        p1_c;
  logic signed [47:0] l2c;
  logic signed [47:0] p2_c;
  logic               v6, rej6;
  aiks_pkg::cval_t    y6 [NL];
  aiks_pkg::cval_t    x6 [NL];

  assign ssf   = aiks_pkg::sside_t'(ss[SB]);
  assign s_val = sq[SB][0].root;
  assign r_val = sq[SB][1].root;
  assign p1_c  = forearm_length * s_val;
  assign l2c   = $signed({1'b0, forearm_length}) * ssf.c;
  assign p2_c  = l2c + $signed({3'b0, upper_arm_length, 30'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= svld[SB];
    end
  end

  // lane 0 base, lane 1 elbow, lanes 2 and 3 shoulder terms
  always_ff @(posedge clk) begin
    if (en) begin
      rej6  <= ssf.reject;
      y6[0] <= {{18{ssf.y[15]}}, ssf.y, 16'b0};
      x6[0] <= {{18{ssf.x[15]}}, ssf.x, 16'b0};
      y6[1] <= {18'b0, s_val};
      x6[1] <= {{18{ssf.c[31]}}, ssf.c};
      y6[2] <= {{17{ssf.h[16]}}, ssf.h, 16'b0};
      x6[2] <= {18'b0, r_val};
      y6[3] <= {3'b0, p1_c};
      x6[3] <= {{2{p2_c[47]}}, p2_c};
    end
  end

  // --------------------------------------------------------------------------
  // S7: quadrant pre-rotation
  // --------------------------------------------------------------------------
  logic                            v7, rej7;
  aiks_pkg::cord_t [NL-1:0]        cl7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rej7 <= rej6;
      for (int i = 0; i < NL; i++) begin
        cl7[i] <= aiks_pkg::prerot(y6[i], x6[i]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // CORDIC row
  // --------------------------------------------------------------------------
  aiks_pkg::cord_t [NL-1:0] cl   [CORDIC_STAGES+1];
  logic                     crej [CORDIC_STAGES+1];
  logic                     cvld [CORDIC_STAGES+1];

  assign cl[0]   = cl7;
  assign crej[0] = rej7;
  assign cvld[0] = v7;

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    aiks_cordic_cell #(.STAGE(k), .PW(1)) u_cordic (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (cvld[k]),
      .lane_in   (cl[k]),
      .side_in   (crej[k]),
      .out_valid (cvld[k+1]),
      .lane_out  (cl[k+1]),
      .side_out  (crej[k+1])
    );
  end

  // --------------------------------------------------------------------------
  // F1: joint angles and servo numerators
  // --------------------------------------------------------------------------
  aiks_pkg::ang_t     za [NL];
  logic signed [NW-1:0] a_base, a_elb, a_sh;
  logic               vf1, rejf1;
  logic signed [NW-1:0] nf1 [5];

  for (genvar g = 0; g < NL; g++) begin : g_ang
    assign za[g] = cl[CORDIC_STAGES][g].zero ? '0 : cl[CORDIC_STAGES][g].z;
  end

  assign a_base = {{(NW-ZW){za[0][ZW-1]}}, za[0]};
  assign a_elb  = {{(NW-ZW){za[1][ZW-1]}}, za[1]};
  assign a_sh   = {{(NW-ZW){za[2][ZW-1]}}, za[2]} + {{(NW-ZW){za[3][ZW-1]}}, za[3]};

  always_ff @(posedge clk) begin
    if (rst) begin
      vf1 <= 1'b0;
    end else if (en) begin
      vf1 <= cvld[CORDIC_STAGES];
    end
  end

  // elbow angle is minus lane 1, pitch is shoulder plus elbow
  always_ff @(posedge clk) begin
    if (en) begin
      rejf1  <= crej[CORDIC_STAGES];
      nf1[0] <= aiks_pkg::OFS_BASE + a_base;
      nf1[1] <= aiks_pkg::OFS_SHOULDER + a_sh;
      nf1[2] <= aiks_pkg::OFS_ELBOW + a_elb;
      nf1[3] <= aiks_pkg::OFS_PITCH - a_sh + a_elb;
      nf1[4] <= aiks_pkg::OFS_ROLL + a_base;
    end
  end

  // --------------------------------------------------------------------------
  // F2: divide by 1440 as a shift by 5 and a reciprocal multiply by 45
  // --------------------------------------------------------------------------
  logic        vf2, rejf2;
  logic [35:0] prod [5];
  logic [11:0] qf2  [5];
  logic        negf2 [5];
  logic        bigf2 [5];

  for (genvar j = 0; j < 5; j++) begin : g_recip
    assign prod[j] = nf1[j][22:5] * aiks_pkg::RECIP_45;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vf2 <= 1'b0;
    end else if (en) begin
      vf2 <= vf1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rejf2 <= rejf1;
      for (int j = 0; j < 5; j++) begin
        qf2[j]   <= prod[j][34:23];
        negf2[j] <= nf1[j][NW-1];
        bigf2[j] <= nf1[j] >= aiks_pkg::SERVO_CAP_N;
      end
    end
  end

  // --------------------------------------------------------------------------
  // F3: saturate, zero rejected targets, hold the result
  // --------------------------------------------------------------------------
  logic [11:0] joint [5];
  logic        out_valid;
  logic [63:0] out_data;

  always_comb begin
    for (int j = 0; j < 5; j++) begin
      if (rejf2 || negf2[j]) begin
        joint[j] = '0;
      end else if (bigf2[j]) begin
        joint[j] = aiks_pkg::SERVO_MAX;
      end else begin
        joint[j] = qf2[j];
      end
    end
  end

  assign en = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vf2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= {3'b000, joint[4], joint[3], joint[2], joint[1], joint[0], !rejf2};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

// File: src/aiks_checker.sv
// ----------------------------------------------------------------------------
// aiks_checker: port-level checks for arm_inverse_kinematics_servo
// Watches the stream ports for reset, flow and result consistency.
// ----------------------------------------------------------------------------
module aiks_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // an empty output stage never blocks input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // a rejected target carries all-zero joints
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[63:1] == '0))
    else $error("rejected target with nonzero joints");

  // wrist roll tracks base by a fixed offset when neither saturates
  a_roll_tracks_base: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[0] && (m_axis_tdata[12:1] != 12'd0) &&
     (m_axis_tdata[12:1] < 12'd3867))
    |-> (m_axis_tdata[60:49] == m_axis_tdata[12:1] + 12'd228))
    else $error("wrist roll inconsistent with base");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind arm_inverse_kinematics_servo aiks_checker u_aiks_checker (.*);

// File: tb/arm_inverse_kinematics_servo_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result checker for the arm inverse kinematics servo
// Watches the configuration port and both stream channels, works out the
// expected joint positions of every accepted target in fixed point and
// compares each returned result field by field, in order.
// ----------------------------------------------------------------------------
module arm_inverse_kinematics_servo_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // target_x, target_y, target_z
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,   // reachable, joint_base, joint_shoulder,
                                      // joint_elbow, joint_wrist_pitch,
                                      // joint_wrist_roll, zero fill
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          pending,
  output int          targets_seen,
  output int          reached_seen
);

  localparam longint QDEG = 16384;

  // result layout, lowest bit first from the right
  typedef struct packed {
    logic [2:0]  fill;
    logic [11:0] roll;
    logic [11:0] pitch;
    logic [11:0] elbow;
    logic [11:0] shoulder;
    logic [11:0] base;
    logic        reach;
  } joints_t;

  localparam longint ARCTAN [30] = '{
    737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7, 4, 2,
    1, 0, 0, 0, 0, 0, 0, 0, 0, 0
  };

  longint shoulder_height;
  longint link_upper;
  longint link_fore;
  joints_t joints_q[$];

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // vectoring arctangent, angle in 1/16384 degree
  function automatic longint vector_angle(longint yv, longint xv);
    longint ang = 0;
    longint t, dx, dy;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      t = xv;
      if (yv >= 0) begin
        xv = yv; yv = -t; ang = 90 * QDEG;
      end else begin
        xv = -yv; yv = t; ang = -90 * QDEG;
      end
    end
    for (int i = 0; i < aiks_pkg::CORDIC_STAGES_DEF; i++) begin
      dx = yv >>> i;
      dy = xv >>> i;
      if (yv >= 0) begin
        xv += dx; yv -= dy; ang += ARCTAN[i];
      end else begin
        xv -= dx; yv += dy; ang -= ARCTAN[i];
      end
    end
    return ang;
  endfunction

  function automatic logic [11:0] servo_pos(longint n);
    longint q;
    if (n < 0) return 12'd0;
    q = n / 1440;
    return (q > 4095) ? 12'd4095 : q[11:0];
  endfunction

  function automatic joints_t solve_joints(logic [47:0] d);
    joints_t o;
    longint x, y, z, h, xy2, num, den, c, s, r, a1, a2, a3;
    x = longint'($signed(d[15:0]));
    y = longint'($signed(d[31:16]));
    z = longint'($signed(d[47:32]));
    o = '0;
    h = z - shoulder_height;
    xy2 = x * x + y * y;
    num = xy2 + h * h - link_upper * link_upper - link_fore * link_fore;
    den = 2 * link_upper * link_fore;
    if (den == 0) return o;
    if (1000 * num > 1001 * den || 1000 * num < -1001 * den) return o;
    if (num >= den) c = longint'(1) << 30;
    else if (num <= -den) c = -(longint'(1) << 30);
    else c = (num * (longint'(1) << 30)) / den;
    s = longint'(floor_sqrt((longint'(1) << 60) - c * c));
    r = longint'(floor_sqrt(longint'(xy2) << 32));
    a1 = vector_angle(y * 65536, x * 65536);
    a3 = -vector_angle(s, c);
    a2 = vector_angle(h * 65536, r)
       + vector_angle(link_fore * s, link_upper * (longint'(1) << 30) + link_fore * c);
    o.reach    = 1'b1;
    o.base     = servo_pos(1820 * 1440 + a1 - 90 * QDEG);
    o.shoulder = servo_pos(2200 * 1440 + a2 - 90 * QDEG);
    o.elbow    = servo_pos(2140 * 1440 - a3);
    o.pitch    = servo_pos(1840 * 1440 - (a2 + a3));
    o.roll     = servo_pos(2048 * 1440 - 90 * QDEG + a1);
    return o;
  endfunction

  assign pending = joints_q.size();

  // track registers, queue predictions, compare returned results
  always @(posedge clk) begin
    joints_t want, got;
    if (rst) begin
      shoulder_height <= 0;
      link_upper <= 1600;
      link_fore <= 1600;
      joints_q.delete();
      errors <= 0;
      targets_seen <= 0;
      reached_seen <= 0;
    end else begin
      if (cfg_we) begin
        case (aiks_pkg::reg_idx_t'(cfg_index))
          aiks_pkg::REG_BASE_HEIGHT: shoulder_height <= longint'($signed(cfg_data));
          aiks_pkg::REG_UPPER_ARM:   link_upper <= longint'(cfg_data[14:0]);
          aiks_pkg::REG_FOREARM:     link_fore <= longint'(cfg_data[14:0]);
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        joints_q.push_back(solve_joints(s_axis_tdata));
        targets_seen <= targets_seen + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (joints_q.size() == 0) begin
          if (errors < 10) $display("ERROR: unexpected result %h", m_axis_tdata);
          errors <= errors + 1;
        end else begin
          want = joints_q.pop_front();
          if (want.reach) reached_seen <= reached_seen + 1;
          if (got.reach !== want.reach || got.base !== want.base ||
              got.shoulder !== want.shoulder || got.elbow !== want.elbow ||
              got.pitch !== want.pitch || got.roll !== want.roll ||
              got.fill !== want.fill) begin
            if (errors < 10)
              $display("ERROR: result mismatch, expected %h got %h", want, got);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// File: tb/arm_inverse_kinematics_servo_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench top for the arm inverse kinematics servo
// Drives directed and random target points under several arm geometries,
// with random idling on both streams and one long output hold-off; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module arm_inverse_kinematics_servo_test;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int errors, pending, targets_seen, reached_seen;
  int sent_n = 0;
  bit calm = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int geo_height = 0;
  int geo_upper = 1600;
  int geo_fore = 1600;

  arm_inverse_kinematics_servo DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  arm_inverse_kinematics_servo_check checker_i (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending),
    .targets_seen(targets_seen), .reached_seen(reached_seen)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // drain side: random stalls, one long hold-off once the pipe is busy
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && sent_n >= 300) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 18);
    end
  end

  // offer one target, idling at random first
  task automatic send_target(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z);
    while (!calm && $urandom_range(99) < 18) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {z, y, x};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent_n++;
  endtask

  // hold the write enable; the caller drops it after the last write
  task automatic write_reg(aiks_pkg::reg_idx_t idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // drain the pipe, then load a new geometry
  task automatic set_geometry(int height, int upper, int fore);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    write_reg(aiks_pkg::REG_BASE_HEIGHT, height[15:0]);
    write_reg(aiks_pkg::REG_UPPER_ARM, upper[15:0]);
    write_reg(aiks_pkg::REG_FOREARM, fore[15:0]);
    cfg_we <= 1'b0;
    geo_height = height;
    geo_upper = upper;
    geo_fore = fore;
  endtask

  function automatic logic signed [15:0] clip16(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // mostly points near the workspace, some anywhere
  task automatic send_random(int count);
    int span, hx, hy, hz;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 20) begin
        send_target(16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        span = ((geo_upper + geo_fore) * 3) / 5;
        if (span > 32767) span = 32767;
        if (span < 1) span = 1;
        hx = $urandom_range(2 * span) - span;
        hy = $urandom_range(2 * span) - span;
        hz = $urandom_range(2 * span) - span;
        send_target(clip16(hx), clip16(hy), clip16(hz + geo_height));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed points under the reset geometry
    send_target(0, 0, 0);              // folded flat, base at the origin
    send_target(3200, 0, 0);           // fully stretched
    send_target(3200, 40, 0);          // just past reach, within tolerance
    send_target(3200, 80, 0);          // past tolerance
    send_target(-3200, 0, 0);
    send_target(0, -3200, 0);
    send_target(0, 0, 3200);
    send_target(-1000, -1000, 500);
    send_target(-1000, 1000, -500);
    send_target(1500, -700, 900);
    send_target(32767, 32767, 32767);
    send_target(-32768, -32768, -32768);
    send_target(32767, -32768, 0);
    send_target(0, 0, -32768);

    // folded with the upper arm shorter than the forearm
    set_geometry(0, 1000, 1600);
    send_target(600, 0, 0);
    send_target(0, 0, 600);
    // zero forearm is never reachable
    set_geometry(0, 1600, 0);
    send_target(1600, 0, 0);
    send_target(0, 0, 0);
    // upper bits beyond the register width are dropped
    set_geometry(0, 16'h8000 | 1600, 16'hffff);
    send_target(1000, 2000, -300);

    // random phases, the extremes among them
    set_geometry(0, 1600, 1600);
    calm = 1'b1;
    send_random(120);
    calm = 1'b0;
    send_random(130);
    set_geometry(-32768, 32767, 32767);
    send_random(230);
    set_geometry(32767, 1, 1);
    send_random(200);
    set_geometry(-500, 800, 2400);
    send_random(240);
    set_geometry($urandom_range(4000) - 2000, $urandom_range(20000) + 1,
                 $urandom_range(20000) + 1);
    send_random(240);
    set_geometry(1200, 2500, 900);
    send_random(240);

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);

    $display("covered %0d targets over 10 geometries, %0d of them reachable",
             targets_seen, reached_seen);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("tb: failure");
    $finish;
  end

endmodule
